FILE: hw/rtl/d2q9_moments_equilibrium_source_core_assert.svh
// Assertion macros for the D2Q9 moments / equilibrium core.
// Used by files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef D2Q9_MOMENTS_EQUILIBRIUM_SOURCE_CORE_ASSERT_SVH
`define D2Q9_MOMENTS_EQUILIBRIUM_SOURCE_CORE_ASSERT_SVH

// check while out of reset
`define D2Q_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also holds across reset
`define D2Q_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/d2q_pkg.sv
// Shared types, constants and fixed-point helpers for the D2Q9 core.
// No dependencies.
package d2q_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DIRECTIONS = 9;
    localparam int Q_W        = 32;
    localparam int CFG_W      = 31;
    localparam int DIR_W      = 4;
    localparam int NUM_W      = Q_W + FRAC_BITS;
    localparam int DIV_STEPS  = Q_W - 1;
    localparam int DIV_LAT    = DIV_STEPS + 2;

    localparam logic [DIR_W-1:0] DIR_LAST = DIR_W'(DIRECTIONS - 1);

    localparam logic [1:0] CFG_INV_RT  = 2'd0;
    localparam logic [1:0] CFG_LAMBDA0 = 2'd1;
    localparam logic [1:0] CFG_MA_SPAN = 2'd2;

    typedef logic signed [Q_W-1:0] t_q;

    localparam t_q Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] RND_Q = ONE_Q - 64'sd1;

    // weights rounded to nearest
    localparam t_q W_REST = t_q'(((4 << FRAC_BITS) + 4) / 9);
    localparam t_q W_AXIS = t_q'(((1 << FRAC_BITS) + 4) / 9);
    localparam t_q W_DIAG = t_q'(((1 << FRAC_BITS) + 18) / 36);

    localparam t_q WEIGHT [DIRECTIONS] = '{W_REST, W_AXIS, W_AXIS, W_AXIS, W_AXIS,
                                           W_DIAG, W_DIAG, W_DIAG, W_DIAG};

    localparam logic signed [1:0] VX [DIRECTIONS] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                                      2'sd1, -2'sd1, -2'sd1, 2'sd1};
    localparam logic signed [1:0] VY [DIRECTIONS] = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                                      2'sd1, 2'sd1, -2'sd1, -2'sd1};

    typedef struct packed {
        logic [CFG_W-1:0] inv_rt;
        logic [CFG_W-1:0] lambda0;
        logic [CFG_W-1:0] ma_span;
    } t_cfg;

    typedef struct packed {
        t_q   rho;
        t_q   ux;
        t_q   uy;
        t_q   lu;
        t_q   fx;
        t_q   fy;
        logic fault;
    } t_cell;

    typedef struct packed {
        logic [DIR_W-1:0] k;
        t_cell            c;
    } t_tag;

    typedef struct packed {
        logic [DIR_W-1:0] k;
        logic             last;
        t_q               feq;
        t_q               src;
        t_q               rho;
        t_q               ux;
        t_q               uy;
        logic             fault;
    } t_res;

    function automatic t_q sat32(input logic signed [63:0] v);
        if (v > 64'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < 64'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[Q_W-1:0];
    endfunction

    // product back to Q, truncated toward zero, saturated
    function automatic t_q qfix(input logic signed [63:0] p);
        logic signed [63:0] t;
        if (p < 0) begin
            t = (p + RND_Q) >>> FRAC_BITS;
        end else begin
            t = p >>> FRAC_BITS;
        end
        return sat32(t);
    endfunction

    // x times a unit velocity component
    function automatic logic signed [Q_W:0] vsel(input logic signed [1:0] v, input t_q x);
        if (v == 2'sd1) begin
            return (Q_W+1)'(x);
        end else if (v == -2'sd1) begin
            return -((Q_W+1)'(x));
        end
        return '0;
    endfunction

endpackage

FILE: hw/rtl/d2q_div.sv
// Pipelined signed Q divider, one quotient bit per stage, saturating.
// Depends on d2q_pkg; the pipeline advances only while i_en is high.
module d2q_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  d2q_pkg::t_q   i_num,
    input  d2q_pkg::t_q   i_den,
    output d2q_pkg::t_q   o_quo
);
    import d2q_pkg::*;

    logic [Q_W-1:0]       a_mag;
    logic [Q_W-1:0]       d_mag;
    logic [NUM_W-1:0]     num_mag;
    logic                 big;

    logic [Q_W:0]         r_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_low [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q   [DIV_STEPS+1];
    logic [Q_W-1:0]       r_den [DIV_STEPS+1];
    logic                 r_neg [DIV_STEPS+1];
    logic                 r_big [DIV_STEPS+1];
    t_q                   r_quo;

    logic [Q_W:0]         n_rem [DIV_STEPS+1];
    logic                 n_qb  [DIV_STEPS+1];

    always_comb begin
        a_mag   = i_num[Q_W-1] ? (~i_num + 1'b1) : i_num;
        d_mag   = i_den[Q_W-1] ? (~i_den + 1'b1) : i_den;
        num_mag = {a_mag, {FRAC_BITS{1'b0}}};
        // quotient would need 2^31 or more
        big     = 63'(num_mag) >= {d_mag, {DIV_STEPS{1'b0}}};
    end

    always_comb begin
        n_rem[0] = '0;
        n_qb[0]  = 1'b0;
        for (int j = 1; j <= DIV_STEPS; j++) begin
            n_rem[j] = {r_rem[j-1][Q_W-1:0], r_low[j-1][DIV_STEPS-1]};
            n_qb[j]  = n_rem[j] >= {1'b0, r_den[j-1]};
            if (n_qb[j]) begin
                n_rem[j] = n_rem[j] - {1'b0, r_den[j-1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (Q_W+1)'(num_mag >> DIV_STEPS);
            r_low[0] <= num_mag[DIV_STEPS-1:0];
            r_q[0]   <= '0;
            r_den[0] <= d_mag;
            r_neg[0] <= i_num[Q_W-1] ^ i_den[Q_W-1];
            r_big[0] <= big;
            for (int j = 1; j <= DIV_STEPS; j++) begin
                r_rem[j] <= n_rem[j];
                r_low[j] <= r_low[j-1] << 1;
                r_q[j]   <= {r_q[j-1][DIV_STEPS-2:0], n_qb[j]};
                r_den[j] <= r_den[j-1];
                r_neg[j] <= r_neg[j-1];
                r_big[j] <= r_big[j-1];
            end
            if (r_big[DIV_STEPS]) begin
                r_quo <= r_neg[DIV_STEPS] ? Q_MIN : Q_MAX;
            end else if (r_neg[DIV_STEPS]) begin
                r_quo <= -{1'b0, r_q[DIV_STEPS]};
            end else begin
                r_quo <= {1'b0, r_q[DIV_STEPS]};
            end
        end
    end

    assign o_quo = r_quo;

endmodule

FILE: hw/rtl/d2q_cell.sv
// Per-cell front end: density, first moments, velocity divide, |u|^2*lambda0.
// Depends on d2q_pkg and d2q_div.
module d2q_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  d2q_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  d2q_pkg::t_q    i_dist [d2q_pkg::DIRECTIONS],
    input  d2q_pkg::t_q    i_fx,
    input  d2q_pkg::t_q    i_fy,
    output logic           o_valid,
    input  logic           i_take,
    output d2q_pkg::t_cell o_cell
);
    import d2q_pkg::*;

    localparam int NF = 9 + DIV_LAT;

    logic          en;
    logic [NF-1:0] r_v;
    t_q            ma_s;
    t_q            lam_s;

    logic signed [Q_W+2:0] r_p0;
    logic signed [Q_W+1:0] r_p1;
    logic signed [Q_W:0]   r_x0;
    logic signed [Q_W+1:0] r_x1;
    logic signed [Q_W:0]   r_y0;
    logic signed [Q_W+1:0] r_y1;
    t_q                    r_fx1;
    t_q                    r_fy1;

    t_q                    n_rho2;
    t_cell                 r_c2;
    t_q                    r_sx2;
    t_q                    r_sy2;

    t_cell                 r_c3;
    logic signed [63:0]    r_mx3;
    logic signed [63:0]    r_my3;

    t_cell                 r_c4;
    t_q                    r_nx4;
    t_q                    r_ny4;

    t_cell                 r_dl [DIV_LAT];
    t_q                    qx;
    t_q                    qy;

    t_cell                 r_c5;
    t_cell                 r_c6;
    logic signed [63:0]    r_uxx6;
    logic signed [63:0]    r_uyy6;
    t_cell                 r_c7;
    t_q                    r_uu7;
    t_cell                 r_c8;
    logic signed [63:0]    r_lup8;
    t_cell                 r_c9;

    assign en      = !r_v[NF-1] || i_take;
    assign o_ready = en;
    assign o_valid = r_v[NF-1];
    assign o_cell  = r_c9;
    assign ma_s    = {1'b0, i_cfg.ma_span};
    assign lam_s   = {1'b0, i_cfg.lambda0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NF-2:0], i_valid};
        end
    end

    assign n_rho2 = sat32(64'(r_p0) + 64'(r_p1));

    d2q_div u_div_x (.i_clk(i_clk), .i_en(en), .i_num(r_nx4), .i_den(r_c4.rho), .o_quo(qx));
    d2q_div u_div_y (.i_clk(i_clk), .i_en(en), .i_num(r_ny4), .i_den(r_c4.rho), .o_quo(qy));

    always_ff @(posedge i_clk) begin
        if (en) begin
            // split adder tree
            r_p0  <= (Q_W+3)'(i_dist[0]) + (Q_W+3)'(i_dist[1]) + (Q_W+3)'(i_dist[2])
                   + (Q_W+3)'(i_dist[3]) + (Q_W+3)'(i_dist[4]);
            r_p1  <= (Q_W+2)'(i_dist[5]) + (Q_W+2)'(i_dist[6]) + (Q_W+2)'(i_dist[7])
                   + (Q_W+2)'(i_dist[8]);
            r_x0  <= (Q_W+1)'(i_dist[1]) - (Q_W+1)'(i_dist[3]);
            r_x1  <= (Q_W+2)'(i_dist[5]) - (Q_W+2)'(i_dist[6]) - (Q_W+2)'(i_dist[7])
                   + (Q_W+2)'(i_dist[8]);
            r_y0  <= (Q_W+1)'(i_dist[2]) - (Q_W+1)'(i_dist[4]);
            r_y1  <= (Q_W+2)'(i_dist[5]) + (Q_W+2)'(i_dist[6]) - (Q_W+2)'(i_dist[7])
                   - (Q_W+2)'(i_dist[8]);
            r_fx1 <= i_fx;
            r_fy1 <= i_fy;

            r_c2  <= '{rho: n_rho2, ux: '0, uy: '0, lu: '0, fx: r_fx1, fy: r_fy1,
                       fault: (n_rho2 == '0)};
            r_sx2 <= sat32(64'(r_x0) + 64'(r_x1));
            r_sy2 <= sat32(64'(r_y0) + 64'(r_y1));

            r_c3  <= r_c2;
            r_mx3 <= ma_s * r_sx2;
            r_my3 <= ma_s * r_sy2;

            r_c4  <= r_c3;
            r_nx4 <= qfix(r_mx3);
            r_ny4 <= qfix(r_my3);

            r_dl[0] <= r_c4;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dl[i] <= r_dl[i-1];
            end

            // zero density: velocity forced to zero
            r_c5 <= '{rho: r_dl[DIV_LAT-1].rho,
                      ux: r_dl[DIV_LAT-1].fault ? '0 : qx,
                      uy: r_dl[DIV_LAT-1].fault ? '0 : qy,
                      lu: r_dl[DIV_LAT-1].lu,
                      fx: r_dl[DIV_LAT-1].fx,
                      fy: r_dl[DIV_LAT-1].fy,
                      fault: r_dl[DIV_LAT-1].fault};

            r_c6   <= r_c5;
            r_uxx6 <= r_c5.ux * r_c5.ux;
            r_uyy6 <= r_c5.uy * r_c5.uy;

            r_c7  <= r_c6;
            r_uu7 <= sat32(64'(qfix(r_uxx6)) + 64'(qfix(r_uyy6)));

            r_c8   <= r_c7;
            r_lup8 <= r_uu7 * lam_s;

            r_c9 <= '{rho: r_c8.rho, ux: r_c8.ux, uy: r_c8.uy, lu: qfix(r_lup8),
                      fx: r_c8.fx, fy: r_c8.fy, fault: r_c8.fault};
        end
    end

endmodule

FILE: hw/rtl/d2q_dir.sv
// Direction sequencer and per-direction equilibrium / source pipeline.
// Depends on d2q_pkg and d2q_div.
module d2q_dir (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  d2q_pkg::t_cfg  i_cfg,
    input  logic           i_cell_valid,
    input  d2q_pkg::t_cell i_cell,
    output logic           o_take,
    output logic           o_valid,
    input  logic           i_ready,
    output d2q_pkg::t_res  o_res
);
    import d2q_pkg::*;

    localparam int NB = 14 + DIV_LAT;

    logic             en;
    logic             take;
    logic [NB-1:0]    r_bv;
    logic             r_busy;
    logic [DIR_W-1:0] r_k;
    t_cell            r_sc;
    t_tag             r_tg [NB-1];
    t_q               ma_s;
    t_q               irt_s;
    t_q               quo;

    t_q                 r_s1, r_dx1, r_dy1;
    logic signed [63:0] r_mp2, r_pxp2, r_pyp2;
    t_q                 r_m13, r_g3;
    logic signed [63:0] r_u1p4;
    t_q                 r_g4;
    t_q                 r_u15, r_g5;
    logic signed [63:0] r_sqp6, r_wrp6;
    t_q                 r_u16, r_g6;
    t_q                 r_poly7, r_wr7, r_g7;
    logic signed [63:0] r_feqp8;
    t_q                 r_g8;
    t_q                 r_feq9, r_g9;
    logic signed [63:0] r_gfp10;
    t_q                 r_feq10;
    t_q                 r_gf11, r_feq11;
    logic signed [63:0] r_gip12;
    t_q                 r_feq12;
    t_q                 r_num13, r_feq13;
    t_q                 r_fd [DIV_LAT];
    t_res               r_res;
    t_q                 n_sq7;

    assign en      = !r_bv[NB-1] || i_ready;
    assign take    = !r_busy || (en && r_k == DIR_LAST);
    assign o_take  = take;
    assign o_valid = r_bv[NB-1];
    assign o_res   = r_res;
    assign ma_s    = {1'b0, i_cfg.ma_span};
    assign irt_s   = {1'b0, i_cfg.inv_rt};

    // one cell held while its nine directions issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_bv   <= '0;
        end else begin
            if (en) begin
                r_bv <= {r_bv[NB-2:0], r_busy};
            end
            if (take) begin
                r_busy <= i_cell_valid;
            end
            if (take && i_cell_valid) begin
                r_k <= '0;
            end else if (en && r_busy) begin
                r_k <= (r_k == DIR_LAST) ? '0 : DIR_W'(r_k + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cell_valid) begin
            r_sc <= i_cell;
        end
    end

    d2q_div u_div (.i_clk(i_clk), .i_en(en), .i_num(r_num13), .i_den(r_tg[12].c.rho),
                   .o_quo(quo));

    assign n_sq7 = qfix(r_sqp6) >>> 1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tg[0] <= '{k: r_k, c: r_sc};
            for (int i = 1; i < NB-1; i++) begin
                r_tg[i] <= r_tg[i-1];
            end

            r_s1  <= sat32(64'(vsel(VX[r_k], r_sc.ux)) + 64'(vsel(VY[r_k], r_sc.uy)));
            r_dx1 <= sat32(64'(vsel(VX[r_k], ma_s)) - 64'(r_sc.ux));
            r_dy1 <= sat32(64'(vsel(VY[r_k], ma_s)) - 64'(r_sc.uy));

            r_mp2  <= ma_s * r_s1;
            r_pxp2 <= r_tg[0].c.fx * r_dx1;
            r_pyp2 <= r_tg[0].c.fy * r_dy1;

            r_m13 <= qfix(r_mp2);
            r_g3  <= sat32(64'(qfix(r_pxp2)) + 64'(qfix(r_pyp2)));

            r_u1p4 <= r_m13 * irt_s;
            r_g4   <= r_g3;

            r_u15 <= qfix(r_u1p4);
            r_g5  <= r_g4;

            r_sqp6 <= r_u15 * r_u15;
            r_wrp6 <= WEIGHT[r_tg[4].k] * r_tg[4].c.rho;
            r_u16  <= r_u15;
            r_g6   <= r_g5;

            r_poly7 <= sat32(ONE_Q + 64'(r_u16) + 64'(n_sq7) - 64'(r_tg[5].c.lu));
            r_wr7   <= qfix(r_wrp6);
            r_g7    <= r_g6;

            r_feqp8 <= r_wr7 * r_poly7;
            r_g8    <= r_g7;

            r_feq9 <= qfix(r_feqp8);
            r_g9   <= r_g8;

            r_gfp10 <= r_g9 * r_feq9;
            r_feq10 <= r_feq9;

            r_gf11  <= qfix(r_gfp10);
            r_feq11 <= r_feq10;

            r_gip12 <= r_gf11 * irt_s;
            r_feq12 <= r_feq11;

            r_num13 <= qfix(r_gip12);
            r_feq13 <= r_feq12;

            r_fd[0] <= r_feq13;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_fd[i] <= r_fd[i-1];
            end

            r_res.k     <= r_tg[NB-2].k;
            r_res.last  <= (r_tg[NB-2].k == DIR_LAST);
            r_res.feq   <= r_fd[DIV_LAT-1];
            r_res.src   <= r_tg[NB-2].c.fault ? '0 : quo;
            r_res.rho   <= r_tg[NB-2].c.rho;
            r_res.ux    <= r_tg[NB-2].c.ux;
            r_res.uy    <= r_tg[NB-2].c.uy;
            r_res.fault <= r_tg[NB-2].c.fault;
        end
    end

endmodule

FILE: hw/rtl/d2q9_moments_equilibrium_source_core.sv
// Top level of the D2Q9 moments, equilibrium and force source core.
// Depends on d2q_pkg, d2q_cell, d2q_dir and the assertion macro header.
//
// One input item is one lattice cell: nine distributions and a body force,
// all signed Q16.16. The cell front end (adder tree, moment scaling, a
// 33-stage pipelined divider for the velocity, then |u|^2*lambda0) feeds a
// sequencer that issues the nine directions, one per cycle while the result
// side is not stalled, into a 47-stage result pipeline (multipliers each
// followed by a register, a second pipelined divider for the source term,
// output register). Results leave in direction order 0..8, tlast on
// direction 8. The result port moves one direction item per cycle when not
// stalled; a new cell is taken while the previous one is still in flight,
// so cells stream without gaps. A stall on the result side holds the result
// pipeline and the front end backs up behind it; nothing is dropped or
// repeated. Config writes are taken at any time but must only be issued while
// the core is idle.
`include "d2q9_moments_equilibrium_source_core_assert.svh"

module d2q9_moments_equilibrium_source_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data,
    // cell input
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata, low to high: dist_0..dist_8, force_x, force_y (32 bits each)
    input  logic [351:0] i_s_axis_tdata,
    // direction results
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata, low to high: f_eq, source, density, velocity_x, velocity_y
    output logic [159:0] o_m_axis_tdata,
    // tuser, low to high: direction (4), div_fault (1)
    output logic [4:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);
    import d2q_pkg::*;

    t_cfg  r_cfg;
    t_q    dist_q [DIRECTIONS];
    t_q    fx;
    t_q    fy;
    logic  cell_valid;
    logic  cell_take;
    t_cell cell_bus;
    t_res  res;
    logic  chk_last;
    logic  chk_rho_zero;
    logic  chk_out_zero;

    assign o_cfg_ready = 1'b1;

    // register file; unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_rt  <= CFG_W'(196608);
            r_cfg.lambda0 <= CFG_W'(98304);
            r_cfg.ma_span <= CFG_W'(65536);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INV_RT:  r_cfg.inv_rt  <= i_cfg_data;
                CFG_LAMBDA0: r_cfg.lambda0 <= i_cfg_data;
                CFG_MA_SPAN: r_cfg.ma_span <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < DIRECTIONS; i++) begin
            dist_q[i] = i_s_axis_tdata[i*Q_W +: Q_W];
        end
    end
    assign fx = i_s_axis_tdata[DIRECTIONS*Q_W +: Q_W];
    assign fy = i_s_axis_tdata[(DIRECTIONS+1)*Q_W +: Q_W];

    d2q_cell u_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_dist  (dist_q),
        .i_fx    (fx),
        .i_fy    (fy),
        .o_valid (cell_valid),
        .i_take  (cell_take),
        .o_cell  (cell_bus)
    );

    d2q_dir u_dir (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cell_valid (cell_valid),
        .i_cell       (cell_bus),
        .o_take       (cell_take),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_res        (res)
    );

    assign o_m_axis_tdata = {res.uy, res.ux, res.rho, res.src, res.feq};
    assign o_m_axis_tuser = {res.fault, res.k};
    assign o_m_axis_tlast = res.last;

    // helper terms for the checks below
    assign chk_last     = (o_m_axis_tuser[3:0] == DIR_LAST);
    assign chk_rho_zero = (o_m_axis_tdata[95:64] == 32'd0);
    assign chk_out_zero = (o_m_axis_tdata[159:96] == 64'd0)
                       && (o_m_axis_tdata[63:32] == 32'd0);

    `D2Q_ASSERT(a_last_dir, o_m_axis_tvalid |-> (o_m_axis_tlast == chk_last), "bad tlast")
    `D2Q_ASSERT(a_fault_rho, o_m_axis_tvalid |-> (o_m_axis_tuser[4] == chk_rho_zero), "bad fault")
    `D2Q_ASSERT(a_fault_zero, o_m_axis_tvalid && o_m_axis_tuser[4] |-> chk_out_zero, "fault out")
    `D2Q_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_m_axis_tvalid, "result valid right after reset")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the D2Q9 moments, equilibrium and force source core.
// Depends on d2q_pkg and d2q9_moments_equilibrium_source_core.
// Predicts the nine direction items of each cell and checks them field by field.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import d2q_pkg::*;

    // index past the register list
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic         i_clk;
    logic         i_rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_data;
    logic         cell_valid;
    logic         cell_ready;
    logic [351:0] cell_data;
    logic         res_valid;
    logic         res_ready;
    logic [159:0] res_data;
    logic [4:0]   res_user;
    logic         res_last;

    d2q9_moments_equilibrium_source_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (cell_valid),
        .o_s_axis_tready (cell_ready),
        .i_s_axis_tdata  (cell_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_user),
        .o_m_axis_tlast  (res_last)
    );

    // Result item as the core should emit it.
    typedef struct {
        logic [3:0]  dir;
        logic [31:0] feq;
        logic [31:0] src;
        logic [31:0] rho;
        logic [31:0] ux;
        logic [31:0] uy;
        logic        last;
        logic        fault;
    } dir_item_t;

    dir_item_t   dir_expected[$];
    int          fail_count;
    int          cells_sent;
    int          items_checked;
    int          fault_cells;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_off = 1'b0;
    event        hold_off_go;
    logic [63:0] inv_rt_q;
    logic [63:0] lambda0_q;
    logic [63:0] ma_span_q;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timeout at %0t", $time);
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Fixed-point predictor: 64-bit signed arithmetic, Q16.16 values.
    // ---------------------------------------------------------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // product truncated toward zero (SV division truncates), then clamped
    function automatic longint qprod(longint a, longint b);
        return clamp32((a * b) / 65536);
    endfunction

    function automatic longint qquot(longint a, longint b);
        return clamp32((a * 65536) / b);
    endfunction

    function automatic longint dir_weight(int k);
        if (k == 0) return ((4 * 65536) + 4) / 9;
        if (k < 5) return (65536 + 4) / 9;
        return (65536 + 18) / 36;
    endfunction

    // Works out the nine expected direction items of one cell.
    task automatic predict_cell(input logic [351:0] cell_word);
        longint vx [9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
        longint vy [9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
        longint d, sum, sx, sy, rho, ux, uy, uu, lu, fx, fy;
        longint s, u1, sq, poly, feq, dx, dy, g, src;
        logic fault;
        dir_item_t e;
        sum = 0; sx = 0; sy = 0; ux = 0; uy = 0;
        for (int k = 0; k < 9; k++) begin
            d = longint'($signed(cell_word[32*k +: 32]));
            sum += d;
            sx += vx[k] * d;
            sy += vy[k] * d;
        end
        fx = longint'($signed(cell_word[288 +: 32]));
        fy = longint'($signed(cell_word[320 +: 32]));
        rho = clamp32(sum);
        fault = (rho == 0);
        if (!fault) begin
            ux = qquot(qprod(ma_span_q, clamp32(sx)), rho);
            uy = qquot(qprod(ma_span_q, clamp32(sy)), rho);
        end
        uu = clamp32(qprod(ux, ux) + qprod(uy, uy));
        lu = qprod(uu, lambda0_q);
        for (int k = 0; k < 9; k++) begin
            s = clamp32(vx[k] * ux + vy[k] * uy);
            u1 = qprod(qprod(ma_span_q, s), inv_rt_q);
            sq = qprod(u1, u1) / 2;
            poly = clamp32(65536 + u1 + sq - lu);
            feq = qprod(qprod(dir_weight(k), rho), poly);
            dx = clamp32(vx[k] * ma_span_q - ux);
            dy = clamp32(vy[k] * ma_span_q - uy);
            g = clamp32(qprod(fx, dx) + qprod(fy, dy));
            src = fault ? 0 : qquot(qprod(qprod(g, feq), inv_rt_q), rho);
            e.dir = 4'(k);
            e.feq = feq[31:0];
            e.src = src[31:0];
            e.rho = rho[31:0];
            e.ux = ux[31:0];
            e.uy = uy[31:0];
            e.last = (k == 8);
            e.fault = fault;
            dir_expected.push_back(e);
        end
        if (fault) fault_cells++;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random back-pressure, optional long hold-off, checking.
    // ---------------------------------------------------------------
    always begin
        @(hold_off_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else if (hold_off) begin
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        dir_item_t e;
        if (i_rst_n && res_valid && res_ready) begin
            if (dir_expected.size() == 0) begin
                $display("%0t: unexpected item, dir %0d", $time, res_user[3:0]);
                fail_count++;
            end else begin
                e = dir_expected.pop_front();
                items_checked++;
                if (res_user[3:0] !== e.dir)
                    $display("%0t: direction exp %0d got %0d", $time, e.dir, res_user[3:0]);
                if (res_data[31:0] !== e.feq)
                    $display("%0t: f_eq exp %h got %h", $time, e.feq, res_data[31:0]);
                if (res_data[63:32] !== e.src)
                    $display("%0t: source exp %h got %h", $time, e.src, res_data[63:32]);
                if (res_data[95:64] !== e.rho)
                    $display("%0t: density exp %h got %h", $time, e.rho, res_data[95:64]);
                if (res_data[127:96] !== e.ux)
                    $display("%0t: velocity_x exp %h got %h", $time, e.ux, res_data[127:96]);
                if (res_data[159:128] !== e.uy)
                    $display("%0t: velocity_y exp %h got %h", $time, e.uy, res_data[159:128]);
                if (res_last !== e.last)
                    $display("%0t: last exp %b got %b", $time, e.last, res_last);
                if (res_user[4] !== e.fault)
                    $display("%0t: div_fault exp %b got %b", $time, e.fault, res_user[4]);
                if (res_user[3:0] !== e.dir || res_data !== {e.uy, e.ux, e.rho, e.src, e.feq}
                        || res_last !== e.last || res_user[4] !== e.fault)
                    fail_count++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // valid stays up after an accept until the next item or an idle cycle
    task automatic send_cell(input logic [351:0] cell_word);
        while ($urandom_range(99) < send_idle_pct) begin
            cell_valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_valid <= 1'b1;
        cell_data <= cell_word;
        @(posedge i_clk);
        while (!cell_ready) @(posedge i_clk);
        predict_cell(cell_word);
        cells_sent++;
    endtask

    task automatic wait_drained();
        cell_valid <= 1'b0;
        while (dir_expected.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_INV_RT:  inv_rt_q = 64'(val);
            CFG_LAMBDA0: lambda0_q = 64'(val);
            CFG_MA_SPAN: ma_span_q = 64'(val);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return 32'(signed'($urandom_range(131072)) - 65536);
            1: return $urandom;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            default: return 32'($urandom_range(32768));
        endcase
    endfunction

    // Mostly physical cells: positive populations with small spread around a random base.
    function automatic logic [351:0] rand_cell();
        logic [351:0] c;
        logic [31:0] base;
        base = 32'($urandom_range(3000, 20000));
        for (int k = 0; k < 9; k++)
            c[32*k +: 32] = base + 32'($urandom_range(2000));
        c[288 +: 32] = 32'(signed'($urandom_range(2000)) - 1000);
        c[320 +: 32] = 32'(signed'($urandom_range(2000)) - 1000);
        if ($urandom_range(9) < 2)
            for (int k = 0; k < 11; k++) c[32*k +: 32] = rand_q();
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        logic [351:0] c;
        c = '0;
        send_cell(c);                          // all zero: density fault
        for (int k = 0; k < 9; k++) c[32*k +: 32] = 32'h0000_1c72;
        send_cell(c);                          // fluid at rest
        c[32 +: 32] = 32'h0000_4000;
        c[288 +: 32] = 32'h0000_0100;
        c[320 +: 32] = 32'hffff_ff00;
        send_cell(c);                          // flow along +x with force
        c = '0;
        c[32 +: 32] = 32'h0001_0000;
        c[96 +: 32] = 32'hffff_0000;           // cancels: zero density, nonzero moment
        send_cell(c);
        c = {11{32'h7fff_ffff}};
        send_cell(c);                          // positive saturation everywhere
        c = {11{32'h8000_0000}};
        send_cell(c);                          // negative saturation everywhere
        c = '1;
        send_cell(c);
        c = '0;
        c[0 +: 32] = 32'h0000_0001;            // tiny density
        c[64 +: 32] = 32'h0000_0001;
        c[288 +: 32] = 32'h7fff_ffff;
        c[320 +: 32] = 32'h8000_0000;
        send_cell(c);
        for (int n = 0; n < 8; n++) begin
            for (int k = 0; k < 11; k++) c[32*k +: 32] = rand_q();
            send_cell(c);
        end
        wait_drained();
    endtask

    task automatic test_config_corners();
        logic [30:0] vals [4] = '{31'd1, 31'h7fff_ffff, 31'd65536, 31'd0};
        for (int i = 0; i < 4; i++) begin
            write_reg(CFG_INV_RT, vals[i]);
            write_reg(CFG_LAMBDA0, vals[3 - i]);
            write_reg(CFG_MA_SPAN, vals[(i + 1) % 4]);
            for (int n = 0; n < 5; n++) send_cell(rand_cell());
            wait_drained();
        end
        write_reg(CFG_SPARE, 31'h1234_5678);   // unused index, ignored
        write_reg(CFG_INV_RT, 31'd196608);
        write_reg(CFG_LAMBDA0, 31'd98304);
        write_reg(CFG_MA_SPAN, 31'(32'h0000_b505));
    endtask

    task automatic test_random_phase(input int s_pct, input int r_pct, input int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++) send_cell(rand_cell());
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> hold_off_go;                        // receiver stalls; input must back up
        for (int n = 0; n < 60; n++) send_cell(rand_cell());
        wait_drained();                        // sender pauses for full drain
        for (int n = 0; n < 10; n++) send_cell(rand_cell());
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cell_valid = 1'b0;
        cell_data = '0;
        fail_count = 0;
        cells_sent = 0;
        items_checked = 0;
        fault_cells = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        inv_rt_q = 196608;
        lambda0_q = 98304;
        ma_span_q = 65536;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_corners();
        test_random_phase(17, 70, 60);
        test_random_phase(70, 17, 60);
        write_reg(CFG_INV_RT, 31'd131072);
        write_reg(CFG_LAMBDA0, 31'd65536);
        test_random_phase(0, 0, 40);
        test_backpressure();

        $display("cells sent %0d, direction items checked %0d, zero-density cells %0d",
                 cells_sent, items_checked, fault_cells);
        $display("covered reset and corner register settings, stalls on both sides");
        if (fail_count == 0 && dir_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
